/* sv/grwi_pkg.sv */
// ----------------------------------------------------------------------------
// grwi_pkg
// Shared constants and codes of the grid ray wall intersection unit.
// ----------------------------------------------------------------------------
package grwi_pkg;

   localparam int MAX_STEPS  = 50;
   localparam int MAP_SIDE   = 64;
   localparam int TILE_BITS  = 6;
   localparam int FRAC_BITS  = 8;
   localparam int TILE_SHIFT = TILE_BITS + FRAC_BITS;
   localparam int ROW_BITS   = $clog2(MAP_SIDE);
   localparam int STEP_W     = $clog2(MAX_STEPS + 1);

   localparam int FULL_TURN  = 5760;
   localparam int QUARTER    = 1440;
   localparam int TRIG_EPS   = 16;

   localparam int CFG_W      = 7;
   localparam int POS_W      = 20;
   localparam int ANGLE_W    = 13;
   localparam int OUT_W      = 24;
   localparam int TRIG_W     = 16;
   localparam int RATIO_W    = 24;
   localparam int RAY_W      = 34;
   localparam int ROM_ADDR_W = 11;
   localparam int ROM_DATA_W = 15;

   localparam int REQ_W      = 72;
   localparam int RSP_W      = 152;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   localparam logic CSR_MAP_WIDTH  = 1'b0;
   localparam logic CSR_MAP_HEIGHT = 1'b1;

   typedef logic [ROW_BITS-1:0] row_addr_type;
   typedef logic [MAP_SIDE-1:0] map_row_type;

endpackage

/* sv/grwi_sin_rom.sv */
// ----------------------------------------------------------------------------
// grwi_sin_rom
// Quarter-wave sine ROM, unsigned Q1.14, one registered read per cycle.
// ----------------------------------------------------------------------------
module grwi_sin_rom (
   input  logic                                clock,
   input  logic [grwi_pkg::ROM_ADDR_W-1:0]     addr,
   output logic [grwi_pkg::ROM_DATA_W-1:0]     data
);

   typedef logic [grwi_pkg::ROM_DATA_W-1:0] sin_table_type [0:grwi_pkg::QUARTER];

   // Q30 Taylor series to x^13, rounded to Q14
   function automatic sin_table_type build_table();
      sin_table_type      tbl;
      longint unsigned    x;
      longint unsigned    x2;
      longint unsigned    t;
      longint unsigned    r;
      longint             s;
      for (int a = 0; a <= grwi_pkg::QUARTER; a++) begin
         x  = (longint'(a) * 64'd3373259426) / 64'd2880;
         x2 = (x * x) >> 30;
         t  = x;
         s  = longint'(x);
         for (int k = 1; k <= 6; k++) begin
            t = (t * x2) >> 30;
            unique case (k)
               1:       t = t / 64'd6;
               2:       t = t / 64'd20;
               3:       t = t / 64'd42;
               4:       t = t / 64'd72;
               5:       t = t / 64'd110;
               default: t = t / 64'd156;
            endcase
            if ((k % 2) == 1) begin
               s = s - longint'(t);
            end else begin
               s = s + longint'(t);
            end
         end
         if (s < 0) begin
            s = 0;
         end
         r = (longint'(s) + 64'd32768) >> 16;
         if (r > 64'd16384) begin
            r = 64'd16384;
         end
         tbl[a] = r[grwi_pkg::ROM_DATA_W-1:0];
      end
      return tbl;
   endfunction

   localparam sin_table_type SIN_TABLE = build_table();

   logic [grwi_pkg::ROM_DATA_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      data_ff <= SIN_TABLE[addr];
   end

   assign data = data_ff;

endmodule

/* sv/grwi_ratio_div.sv */
// ----------------------------------------------------------------------------
// grwi_ratio_div
// Radix-2 restoring divider for num*16384/den, truncated and saturated.
// ----------------------------------------------------------------------------
module grwi_ratio_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [grwi_pkg::TRIG_W-1:0]     num,
   input  logic signed [grwi_pkg::TRIG_W-1:0]     den,
   output logic                                   done,
   output logic signed [grwi_pkg::RATIO_W-1:0]    ratio
);

   localparam int MAG_W = grwi_pkg::TRIG_W - 1;
   localparam int DVD_W = MAG_W + 14;
   localparam int CNT_W = $clog2(DVD_W);
   localparam int SAT_W = grwi_pkg::RATIO_W - 1;

   logic                busy_ff;
   logic                fin_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [MAG_W:0]      rem_ff;
   logic [DVD_W-1:0]    dvd_ff;
   logic [MAG_W-1:0]    den_ff;
   logic                neg_ff;

   logic [grwi_pkg::TRIG_W-1:0] num_abs;
   logic [grwi_pkg::TRIG_W-1:0] den_abs;
   logic [MAG_W:0]      trial;
   logic                fits;
   logic [SAT_W-1:0]    mag;

   assign num_abs = num[grwi_pkg::TRIG_W-1] ? -num : num;
   assign den_abs = den[grwi_pkg::TRIG_W-1] ? -den : den;
   assign trial   = {rem_ff[MAG_W-1:0], dvd_ff[DVD_W-1]};
   assign fits    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         fin_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            fin_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= {num_abs[MAG_W-1:0], 14'b0};
         rem_ff <= '0;
         den_ff <= den_abs[MAG_W-1:0];
         neg_ff <= num[grwi_pkg::TRIG_W-1] ^ den[grwi_pkg::TRIG_W-1];
         cnt_ff <= CNT_W'(DVD_W - 1);
      end else if (busy_ff) begin
         rem_ff <= fits ? (trial - {1'b0, den_ff}) : trial;
         dvd_ff <= {dvd_ff[DVD_W-2:0], fits};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign mag   = (dvd_ff[DVD_W-1:SAT_W] != '0) ? '1 : dvd_ff[SAT_W-1:0];
   assign ratio = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   assign done  = fin_ff;

endmodule

/* sv/grwi_map_mem.sv */
// ----------------------------------------------------------------------------
// grwi_map_mem
// Wall bitmap, one map row per word, with a row-by-row clear after reset.
// ----------------------------------------------------------------------------
module grwi_map_mem (
   input  logic                    clock,
   input  logic                    reset,
   input  grwi_pkg::row_addr_type  rd_addr,
   output grwi_pkg::map_row_type   rd_data,
   input  logic                    wr_en,
   input  grwi_pkg::row_addr_type  wr_addr,
   input  grwi_pkg::map_row_type   wr_data,
   output logic                    busy
);

   grwi_pkg::map_row_type  rows_mem [0:grwi_pkg::MAP_SIDE-1];
   grwi_pkg::map_row_type  rd_data_ff;
   grwi_pkg::row_addr_type clr_cnt_ff;
   logic                   clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == grwi_pkg::ROW_BITS'(grwi_pkg::MAP_SIDE - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         rows_mem[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         rows_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= rows_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

/* sv/grid_ray_wall_intersection_unit.sv */
// ----------------------------------------------------------------------------
// grid_ray_wall_intersection_unit
// Grid ray caster: keeps a wall bitmap and reports the first wall crossing
// on vertical and on horizontal grid lines for each cast.
// ----------------------------------------------------------------------------
//  channel | direction | transfer
//  req     | in        | write one map cell or cast one ray (tuser = operation)
//  rsp     | out       | one result per cast, none per cell write
//  csr     | in        | map_width (index 0), map_height (index 1)
//
//  Cell write: bitmap row read, modify, write back.
//  Cast: setup, divide and distance math plus the march of each active pass,
//  one bitmap probe at a time, at most MAX_STEPS probes per pass. Cast time is
//  set by the ratio divide, used once per active pass, and the single bitmap
//  read port.
//  After reset the bitmap is cleared one row a cycle; req_tready
//  stays low meanwhile. A waiting result does not block the next request.
// ----------------------------------------------------------------------------
module grid_ray_wall_intersection_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // cell_col, cell_row, cell_is_wall, player_x, player_y, ray_angle
   input  logic [grwi_pkg::REQ_W-1:0]    req_tdata,
   // operation
   input  logic [0:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // vert_hit, vert_distance, vert_hit_x, vert_hit_y,
   // horiz_hit, horiz_distance, horiz_hit_x, horiz_hit_y
   output logic [grwi_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [0:0]                    csr_index,
   input  logic [grwi_pkg::CFG_W-1:0]    csr_data
);

   localparam int TS = grwi_pkg::TILE_SHIFT;
   localparam int RW = grwi_pkg::RAY_W;
   localparam int PW = grwi_pkg::POS_W;
   localparam int OW = grwi_pkg::OUT_W;
   localparam int CW = grwi_pkg::CFG_W;
   localparam int RB = grwi_pkg::ROW_BITS;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_WR_RD  = 4'd1;
   localparam logic [3:0] S_WR_WB  = 4'd2;
   localparam logic [3:0] S_TRIG_S = 4'd3;
   localparam logic [3:0] S_TRIG_C = 4'd4;
   localparam logic [3:0] S_TRIG_W = 4'd5;
   localparam logic [3:0] S_SETUP  = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_MUL    = 4'd8;
   localparam logic [3:0] S_INIT   = 4'd9;
   localparam logic [3:0] S_MARCH  = 4'd10;
   localparam logic [3:0] S_DMUL1  = 4'd11;
   localparam logic [3:0] S_DMUL2  = 4'd12;
   localparam logic [3:0] S_DSUM   = 4'd13;
   localparam logic [3:0] S_NEXT   = 4'd14;
   localparam logic [3:0] S_FINISH = 4'd15;

   localparam logic signed [OW-1:0] DIST_MAX = {1'b0, {(OW-1){1'b1}}};
   localparam logic signed [RW-1:0] TILE_Q   = RW'(1) <<< TS;

   function automatic logic signed [OW-1:0] sat24(input logic signed [39:0] v);
      logic signed [39:0] hi;
      logic signed [39:0] lo;
      hi = 40'(DIST_MAX);
      lo = -hi - 40'sd1;
      if (v > hi) begin
         return DIST_MAX;
      end else if (v < lo) begin
         return -DIST_MAX - 24'sd1;
      end
      return v[OW-1:0];
   endfunction

   // control
   logic [3:0]                       state_ff, state_in;
   logic                             rsp_valid_ff;
   logic [CW-1:0]                    map_w_ff, map_h_ff;
   logic                             pass_ff;
   logic [grwi_pkg::STEP_W-1:0]      iss_cnt_ff;
   logic                             probe_live_ff;

   // datapath
   logic [RB-1:0]                    wr_col_ff, wr_row_ff;
   logic                             wr_wall_ff;
   logic [PW-1:0]                    px_ff, py_ff;
   logic [grwi_pkg::ANGLE_W-1:0]     angle_ff;
   logic signed [grwi_pkg::TRIG_W-1:0] sin_ff, cos_ff;
   logic                             rneg_ff;
   logic signed [grwi_pkg::RATIO_W-1:0] ratio_ff;
   logic signed [RW-1:0]             maj_ff;
   logic                             fwd_ff;
   logic signed [39:0]               prod_ff;
   logic signed [RW-1:0]             rx_ff, ry_ff, sx_ff, sy_ff;
   logic signed [RW-1:0]             probe_x_ff, probe_y_ff;
   logic                             probe_ok_ff, probe_last_ff;
   logic [RB-1:0]                    probe_col_ff;
   logic signed [36:0]               dprod_ff, dprod2_ff;
   logic                             v_hit_ff, h_hit_ff;
   logic signed [OW-1:0]             v_dist_ff, v_x_ff, v_y_ff;
   logic signed [OW-1:0]             h_dist_ff, h_x_ff, h_y_ff;
   logic [grwi_pkg::RSP_W-1:0]       rsp_data_ff;

   // combinational
   logic                             req_take, rsp_load;
   logic [grwi_pkg::ANGLE_W-1:0]     in_angle, cos_angle, trig_angle, trig_r;
   logic [1:0]                       trig_q;
   logic [grwi_pkg::ROM_ADDR_W-1:0]  rom_addr;
   logic [grwi_pkg::ROM_DATA_W-1:0]  rom_data;
   logic signed [grwi_pkg::TRIG_W-1:0] rom_val;
   logic signed [grwi_pkg::TRIG_W-1:0] num_t, den_t;
   logic                             pass_active, den_pos, fwd_t;
   logic [PW-1:0]                    p_major, p_minor;
   logic signed [RW-1:0]             base_t, maj_t;
   logic signed [RW-1:0]             diff_full;
   logic signed [15:0]               diff16;
   logic signed [39:0]               rnd_minor;
   logic signed [RW-1:0]             minor_start, step_major, step_minor;
   logic [CW-1:0]                    lim_w, lim_h, col7, row7;
   logic                             ok_x, ok_y, probe_ok;
   logic                             div_start, div_done;
   logic signed [grwi_pkg::RATIO_W-1:0] div_ratio;
   grwi_pkg::row_addr_type           mem_rd_addr;
   grwi_pkg::map_row_type            mem_rd_data, row_new;
   logic                             mem_busy, mem_wr_en;
   logic                             probe_hit, probe_miss;
   logic signed [PW:0]               dx, dy;
   logic signed [39:0]               dsum;
   logic                             res_we, res_hit;
   logic signed [OW-1:0]             res_dist, res_x, res_y;

   assign req_tready = (state_ff == S_IDLE) && !mem_busy;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   // angle handling
   assign in_angle  = (req_tdata[65:53] >= 13'(grwi_pkg::FULL_TURN)) ?
                      req_tdata[65:53] - 13'(grwi_pkg::FULL_TURN) : req_tdata[65:53];
   assign cos_angle = (angle_ff >= 13'(grwi_pkg::FULL_TURN - grwi_pkg::QUARTER)) ?
                      angle_ff - 13'(grwi_pkg::FULL_TURN - grwi_pkg::QUARTER) :
                      angle_ff + 13'(grwi_pkg::QUARTER);
   assign trig_angle = (state_ff == S_TRIG_C) ? cos_angle : angle_ff;

   always_comb begin
      priority if (trig_angle >= 13'(3 * grwi_pkg::QUARTER)) begin
         trig_q = 2'd3;
      end else if (trig_angle >= 13'(2 * grwi_pkg::QUARTER)) begin
         trig_q = 2'd2;
      end else if (trig_angle >= 13'(grwi_pkg::QUARTER)) begin
         trig_q = 2'd1;
      end else begin
         trig_q = 2'd0;
      end
      trig_r   = trig_angle - 13'(trig_q) * 13'(grwi_pkg::QUARTER);
      rom_addr = trig_q[0] ? grwi_pkg::ROM_ADDR_W'(13'(grwi_pkg::QUARTER) - trig_r)
                           : grwi_pkg::ROM_ADDR_W'(trig_r);
   end

   assign rom_val = rneg_ff ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

   // pass setup
   assign num_t       = pass_ff ? cos_ff : sin_ff;
   assign den_t       = pass_ff ? sin_ff : cos_ff;
   assign pass_active = (den_t > 16'(grwi_pkg::TRIG_EPS)) ||
                        (den_t < -16'(grwi_pkg::TRIG_EPS));
   assign den_pos     = den_t > 16'sd0;
   assign fwd_t       = pass_ff ? !den_pos : den_pos;
   assign p_major     = pass_ff ? py_ff : px_ff;
   assign p_minor     = pass_ff ? px_ff : py_ff;
   assign base_t      = $signed(RW'({p_major[PW-1:TS], {TS{1'b0}}}));
   assign maj_t       = fwd_t ? base_t + TILE_Q : base_t - RW'(1);
   assign diff_full   = $signed(RW'(p_major)) - maj_ff;
   assign diff16      = diff_full[15:0];
   assign rnd_minor   = (prod_ff + 40'sd8192) >>> TS;
   assign minor_start = rnd_minor[RW-1:0] + $signed(RW'(p_minor));
   assign step_major  = fwd_ff ? TILE_Q : -TILE_Q;
   assign step_minor  = fwd_ff ? -RW'(ratio_ff) : RW'(ratio_ff);
   assign div_start   = (state_ff == S_SETUP) && pass_active;

   // probe address and bounds for the current ray point
   assign lim_w = (map_w_ff > CW'(grwi_pkg::MAP_SIDE)) ? CW'(grwi_pkg::MAP_SIDE) : map_w_ff;
   assign lim_h = (map_h_ff > CW'(grwi_pkg::MAP_SIDE)) ? CW'(grwi_pkg::MAP_SIDE) : map_h_ff;
   assign col7  = rx_ff[TS+CW-1:TS];
   assign row7  = ry_ff[TS+CW-1:TS];
   assign ok_x  = (rx_ff[RW-1:TS+CW] == '0) && (col7 < lim_w);
   assign ok_y  = (ry_ff[RW-1:TS+CW] == '0) && (row7 < lim_h);
   assign probe_ok = ok_x && ok_y && !((col7 == '0) && (row7 == '0));

   assign mem_rd_addr = (state_ff == S_MARCH) ? row7[RB-1:0] : wr_row_ff;
   assign mem_wr_en   = (state_ff == S_WR_WB);

   always_comb begin
      row_new            = mem_rd_data;
      row_new[wr_col_ff] = wr_wall_ff;
   end

   assign probe_hit  = (state_ff == S_MARCH) && probe_live_ff && probe_ok_ff &&
                       mem_rd_data[probe_col_ff];
   assign probe_miss = (state_ff == S_MARCH) && probe_live_ff && !probe_hit &&
                       probe_last_ff;

   // projected distance
   assign dx   = $signed({1'b0, probe_x_ff[PW-1:0]}) - $signed({1'b0, px_ff});
   assign dy   = $signed({1'b0, probe_y_ff[PW-1:0]}) - $signed({1'b0, py_ff});
   assign dsum = (40'(dprod_ff) - 40'(dprod2_ff) + 40'sd8192) >>> TS;

   always_comb begin
      res_we   = 1'b0;
      res_hit  = 1'b0;
      res_dist = DIST_MAX;
      res_x    = sat24(40'(rx_ff));
      res_y    = sat24(40'(ry_ff));
      if (state_ff == S_SETUP && !pass_active) begin
         res_we = 1'b1;
         res_x  = $signed(OW'(px_ff));
         res_y  = $signed(OW'(py_ff));
      end else if (probe_miss) begin
         res_we = 1'b1;
      end else if (state_ff == S_DSUM) begin
         res_we   = 1'b1;
         res_hit  = 1'b1;
         res_dist = sat24(dsum);
         res_x    = sat24(40'(probe_x_ff));
         res_y    = sat24(40'(probe_y_ff));
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = (req_tuser[0] == grwi_pkg::OP_CAST) ? S_TRIG_S : S_WR_RD;
            end
         end
         S_WR_RD:  state_in = S_WR_WB;
         S_WR_WB:  state_in = S_IDLE;
         S_TRIG_S: state_in = S_TRIG_C;
         S_TRIG_C: state_in = S_TRIG_W;
         S_TRIG_W: state_in = S_SETUP;
         S_SETUP:  state_in = pass_active ? S_DIV : S_NEXT;
         S_DIV: begin
            if (div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL:    state_in = S_INIT;
         S_INIT:   state_in = S_MARCH;
         S_MARCH: begin
            if (probe_hit) begin
               state_in = S_DMUL1;
            end else if (probe_miss) begin
               state_in = S_NEXT;
            end
         end
         S_DMUL1:  state_in = S_DMUL2;
         S_DMUL2:  state_in = S_DSUM;
         S_DSUM:   state_in = S_NEXT;
         S_NEXT:   state_in = pass_ff ? S_FINISH : S_SETUP;
         S_FINISH: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         map_w_ff      <= CW'(64);
         map_h_ff      <= CW'(64);
         pass_ff       <= 1'b0;
         iss_cnt_ff    <= '0;
         probe_live_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index[0])
               grwi_pkg::CSR_MAP_WIDTH:  map_w_ff <= csr_data;
               grwi_pkg::CSR_MAP_HEIGHT: map_h_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == S_TRIG_W) begin
            pass_ff <= 1'b0;
         end else if (state_ff == S_NEXT) begin
            pass_ff <= 1'b1;
         end
         if (state_ff == S_INIT) begin
            iss_cnt_ff    <= '0;
            probe_live_ff <= 1'b0;
         end else if (state_ff == S_MARCH) begin
            iss_cnt_ff    <= iss_cnt_ff + 1'b1;
            probe_live_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         wr_col_ff  <= req_tdata[5:0];
         wr_row_ff  <= req_tdata[11:6];
         wr_wall_ff <= req_tdata[12];
         px_ff      <= req_tdata[32:13];
         py_ff      <= req_tdata[52:33];
         angle_ff   <= in_angle;
      end
      if (state_ff == S_TRIG_S || state_ff == S_TRIG_C) begin
         rneg_ff <= trig_q[1];
      end
      if (state_ff == S_TRIG_C) begin
         sin_ff <= rom_val;
      end
      if (state_ff == S_TRIG_W) begin
         cos_ff <= rom_val;
      end
      if (state_ff == S_SETUP) begin
         maj_ff <= maj_t;
         fwd_ff <= fwd_t;
      end
      if (div_done) begin
         ratio_ff <= div_ratio;
      end
      if (state_ff == S_MUL) begin
         prod_ff <= diff16 * ratio_ff;
      end
      if (state_ff == S_INIT) begin
         sx_ff <= pass_ff ? step_minor : step_major;
         sy_ff <= pass_ff ? step_major : step_minor;
         rx_ff <= pass_ff ? minor_start : maj_ff;
         ry_ff <= pass_ff ? maj_ff : minor_start;
      end else if (state_ff == S_MARCH) begin
         // keep the hit point for the distance math
         if (!probe_hit) begin
            probe_x_ff <= rx_ff;
            probe_y_ff <= ry_ff;
         end
         probe_ok_ff   <= probe_ok;
         probe_col_ff  <= col7[RB-1:0];
         probe_last_ff <= iss_cnt_ff == grwi_pkg::STEP_W'(grwi_pkg::MAX_STEPS - 1);
         rx_ff         <= rx_ff + sx_ff;
         ry_ff         <= ry_ff + sy_ff;
      end
      if (state_ff == S_DMUL1) begin
         dprod_ff <= cos_ff * dx;
      end
      if (state_ff == S_DMUL2) begin
         dprod2_ff <= sin_ff * dy;
      end
      if (res_we) begin
         if (pass_ff) begin
            h_hit_ff  <= res_hit;
            h_dist_ff <= res_dist;
            h_x_ff    <= res_x;
            h_y_ff    <= res_y;
         end else begin
            v_hit_ff  <= res_hit;
            v_dist_ff <= res_dist;
            v_x_ff    <= res_x;
            v_y_ff    <= res_y;
         end
      end
      if (rsp_load) begin
         rsp_data_ff <= {6'b0, h_y_ff, h_x_ff, h_dist_ff, h_hit_ff,
                         v_y_ff, v_x_ff, v_dist_ff, v_hit_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   grwi_sin_rom u_sin_rom (
      .clock (clock),
      .addr  (rom_addr),
      .data  (rom_data)
   );

   grwi_ratio_div u_ratio_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_t),
      .den   (den_t),
      .done  (div_done),
      .ratio (div_ratio)
   );

   grwi_map_mem u_map_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_row_ff),
      .wr_data (row_new),
      .busy    (mem_busy)
   );

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MARCH |-> iss_cnt_ff <= grwi_pkg::STEP_W'(grwi_pkg::MAX_STEPS))
      else $error("probe count past limit");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside its wait state");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FINISH)
      else $error("result raised outside finish");

   a_write_back: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WR_WB |-> $past(state_ff) == S_WR_RD)
      else $error("row write back without read");

endmodule
